[design/scanset_parse_and_match_top_macros.svh]
// ---------------------------------------------------------------------------
// scanset_parse_and_match_top_macros
// assertion macros shared by the scan-set blocks
// ---------------------------------------------------------------------------
// each macro expects clk and rst_n in the module scope
`ifndef SCANSET_PARSE_AND_MATCH_TOP_MACROS_SVH
`define SCANSET_PARSE_AND_MATCH_TOP_MACROS_SVH

// same-cycle implication
`define SPM_ASSERT_IMPL(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scan-set assertion failed");

// next-cycle implication
`define SPM_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scan-set assertion failed");

`endif

[design/spm_pkg.sv]
// ---------------------------------------------------------------------------
// spm_pkg
// shared types and constants of the scan-set parser and matcher
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package spm_pkg;

    // store geometry
    localparam int ENTRY_SLOTS = 16;
    localparam int CNT_W       = $clog2(ENTRY_SLOTS);
    localparam int SLOT_LAST   = ENTRY_SLOTS - 1;
    localparam int UNIT_W      = 16;

    // special code units
    localparam logic [UNIT_W-1:0] CH_CARET = 16'h005E;
    localparam logic [UNIT_W-1:0] CH_CLOSE = 16'h005D;
    localparam logic [UNIT_W-1:0] CH_DASH  = 16'h002D;

    // request kind in tuser
    localparam logic MODE_SPEC  = 1'b0;
    localparam logic MODE_QUERY = 1'b1;

    // parse phase of the bracket text
    typedef enum logic [2:0] {
        PH_FIRST,
        PH_AFTER_CARET,
        PH_MAIN,
        PH_HOLD,
        PH_DASH,
        PH_DONE
    } phase_t;

    // sequencer state
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_EXEC,
        ST_ADD2,
        ST_OUT
    } seq_state_t;

    // datapath operation
    typedef enum logic [1:0] {
        OP_NONE,
        OP_SINGLE,
        OP_RANGE,
        OP_CARET
    } op_t;

    // operand source for a single add
    typedef enum logic [1:0] {
        SRC_HOLD,
        SRC_UNIT,
        SRC_DASH
    } src_t;

    // controller to datapath
    typedef struct packed {
        logic capture;
        logic clear;
        logic query;
        logic spec_exec;
        op_t  op;
        src_t src;
        logic load_hold;
    } cmd_t;

    // datapath to controller
    typedef struct packed {
        logic start_set;
        logic item_mode;
        logic item_last;
        logic is_caret;
        logic is_close;
        logic is_dash;
    } status_t;

endpackage

`default_nettype wire

[design/spm_datapath.sv]
// ---------------------------------------------------------------------------
// spm_datapath
// item register, single and range stores, lookahead unit, counters and
// parallel membership compare
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "scanset_parse_and_match_top_macros.svh"

module spm_datapath (
    input  wire logic                        clk,
    input  wire logic                        rst_n,
    input  wire spm_pkg::cmd_t               cmd,
    output spm_pkg::status_t                 sts,
    input  wire logic                        in_mode,
    input  wire logic [spm_pkg::UNIT_W-1:0]  in_unit,
    input  wire logic                        in_first,
    input  wire logic                        in_last,
    output logic                             in_set,
    output logic                             add_ok,
    output logic [spm_pkg::UNIT_W-1:0]       consumed
);

    // captured request
    logic                        mode_reg;
    logic                        last_reg;
    logic [spm_pkg::UNIT_W-1:0]  unit_reg;
    logic [spm_pkg::UNIT_W-1:0]  hold_reg;

    // stores
    logic [spm_pkg::UNIT_W-1:0]  single_store [spm_pkg::ENTRY_SLOTS];
    logic [spm_pkg::UNIT_W-1:0]  range_lo     [spm_pkg::ENTRY_SLOTS];
    logic [spm_pkg::UNIT_W-1:0]  range_hi     [spm_pkg::ENTRY_SLOTS];

    // control state
    logic [spm_pkg::CNT_W-1:0]   single_cnt_reg, single_cnt_next;
    logic [spm_pkg::CNT_W-1:0]   range_cnt_reg, range_cnt_next;
    logic                        incl_reg, incl_next;
    logic [spm_pkg::UNIT_W-1:0]  consumed_reg, consumed_next;
    logic                        last_add_reg, last_add_next;
    logic                        in_set_reg, in_set_next;

    logic                        single_full;
    logic                        range_full;
    logic [spm_pkg::UNIT_W-1:0]  src_val;
    logic [spm_pkg::UNIT_W-1:0]  r_lo;
    logic [spm_pkg::UNIT_W-1:0]  r_hi;
    logic [1:0]                  bump;
    logic [spm_pkg::UNIT_W:0]    bump_sum;
    logic                        member_hit;

    // status toward the controller
    assign sts.start_set = (in_mode == spm_pkg::MODE_SPEC) && in_first;
    assign sts.item_mode = mode_reg;
    assign sts.item_last = last_reg;
    assign sts.is_caret  = (unit_reg == spm_pkg::CH_CARET);
    assign sts.is_close  = (unit_reg == spm_pkg::CH_CLOSE);
    assign sts.is_dash   = (unit_reg == spm_pkg::CH_DASH);

    // capture request and lookahead unit
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            mode_reg <= in_mode;
            last_reg <= in_last;
            unit_reg <= in_unit;
        end
        if (cmd.load_hold)
        begin
            hold_reg <= unit_reg;
        end
    end

    // operand selection
    always_comb
    begin
        unique case (cmd.src)
            spm_pkg::SRC_HOLD: src_val = hold_reg;
            spm_pkg::SRC_UNIT: src_val = unit_reg;
            spm_pkg::SRC_DASH: src_val = spm_pkg::CH_DASH;
            default:           src_val = unit_reg;
        endcase
    end

    // range bounds in order
    assign r_lo = (unit_reg < hold_reg) ? unit_reg : hold_reg;
    assign r_hi = (unit_reg < hold_reg) ? hold_reg : unit_reg;

    assign single_full = (single_cnt_reg >= spm_pkg::CNT_W'(spm_pkg::SLOT_LAST));
    assign range_full  = (range_cnt_reg >= spm_pkg::CNT_W'(spm_pkg::SLOT_LAST));

    // store writes at the fill count
    always_ff @(posedge clk)
    begin
        if (!cmd.clear && cmd.op == spm_pkg::OP_SINGLE && !single_full)
        begin
            single_store[single_cnt_reg] <= src_val;
        end
        if (!cmd.clear && cmd.op == spm_pkg::OP_RANGE && !range_full)
        begin
            range_lo[range_cnt_reg] <= r_lo;
            range_hi[range_cnt_reg] <= r_hi;
        end
    end

    // membership over all filled entries
    always_comb
    begin
        member_hit = 1'b0;
        for (int i = 0; i < spm_pkg::ENTRY_SLOTS; i++)
        begin
            if ((spm_pkg::CNT_W'(i) < single_cnt_reg) && (single_store[i] == unit_reg))
            begin
                member_hit = 1'b1;
            end
            if ((spm_pkg::CNT_W'(i) < range_cnt_reg) && (unit_reg >= range_lo[i])
                && (unit_reg <= range_hi[i]))
            begin
                member_hit = 1'b1;
            end
        end
    end

    // consumed count increment
    always_comb
    begin
        unique case (cmd.op)
            spm_pkg::OP_SINGLE: bump = 2'd1;
            spm_pkg::OP_CARET:  bump = 2'd1;
            spm_pkg::OP_RANGE:  bump = 2'd3;
            default:            bump = 2'd0;
        endcase
    end

    assign bump_sum = {1'b0, consumed_reg} + (spm_pkg::UNIT_W + 1)'(bump);

    // next values of counters and flags
    always_comb
    begin
        single_cnt_next = single_cnt_reg;
        range_cnt_next  = range_cnt_reg;
        incl_next       = incl_reg;
        last_add_next   = last_add_reg;
        consumed_next   = bump_sum[spm_pkg::UNIT_W] ? {spm_pkg::UNIT_W{1'b1}}
                                                    : bump_sum[spm_pkg::UNIT_W-1:0];
        in_set_next     = in_set_reg;
        if (cmd.clear)
        begin
            single_cnt_next = '0;
            range_cnt_next  = '0;
            incl_next       = 1'b1;
            last_add_next   = 1'b0;
            consumed_next   = '0;
        end
        else
        begin
            unique case (cmd.op)
                spm_pkg::OP_SINGLE:
                begin
                    last_add_next = !single_full;
                    if (!single_full)
                    begin
                        single_cnt_next = single_cnt_reg + spm_pkg::CNT_W'(1);
                    end
                end
                spm_pkg::OP_RANGE:
                begin
                    last_add_next = !range_full;
                    if (!range_full)
                    begin
                        range_cnt_next = range_cnt_reg + spm_pkg::CNT_W'(1);
                    end
                end
                spm_pkg::OP_CARET:
                begin
                    incl_next = 1'b0;
                end
                default:
                begin
                end
            endcase
        end
        // answer register
        if (cmd.query)
        begin
            in_set_next = incl_reg ? member_hit : !member_hit;
        end
        else if (cmd.spec_exec)
        begin
            in_set_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            single_cnt_reg <= '0;
            range_cnt_reg  <= '0;
            incl_reg       <= 1'b1;
            consumed_reg   <= '0;
            last_add_reg   <= 1'b0;
            in_set_reg     <= 1'b0;
        end
        else
        begin
            single_cnt_reg <= single_cnt_next;
            range_cnt_reg  <= range_cnt_next;
            incl_reg       <= incl_next;
            consumed_reg   <= consumed_next;
            last_add_reg   <= last_add_next;
            in_set_reg     <= in_set_next;
        end
    end

    assign in_set   = in_set_reg;
    assign add_ok   = last_add_reg;
    assign consumed = consumed_reg;

    // checks
    `SPM_ASSERT_IMPL(a_single_bound, 1'b1,
        single_cnt_reg <= spm_pkg::CNT_W'(spm_pkg::SLOT_LAST))
    `SPM_ASSERT_IMPL(a_range_bound, 1'b1,
        range_cnt_reg <= spm_pkg::CNT_W'(spm_pkg::SLOT_LAST))
    `SPM_ASSERT_NEXT(a_consumed_mono, !cmd.clear, consumed_reg >= $past(consumed_reg))

endmodule

`default_nettype wire

[design/spm_ctrl.sv]
// ---------------------------------------------------------------------------
// spm_ctrl
// request sequencer and bracket-text parse controller
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "scanset_parse_and_match_top_macros.svh"

module spm_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    output logic                   out_valid,
    input  wire logic              out_ready,
    input  wire spm_pkg::status_t  sts,
    output spm_pkg::cmd_t          cmd,
    output logic                   spec_done
);

    spm_pkg::seq_state_t state_reg, state_next;
    spm_pkg::phase_t     phase_reg, phase_next;
    spm_pkg::op_t        op2_reg, op2_next;
    spm_pkg::src_t       src2_reg, src2_next;

    // decoded step of one spec unit
    spm_pkg::phase_t     dec_phase;
    spm_pkg::op_t        dec_op1;
    spm_pkg::src_t       dec_src1;
    spm_pkg::op_t        dec_op2;
    spm_pkg::src_t       dec_src2;
    logic                dec_load;
    spm_pkg::phase_t     body_phase;
    logic                body_load;

    // unit after an opening part: close ends, anything else is held
    assign body_phase = sts.is_close ? spm_pkg::PH_DONE : spm_pkg::PH_HOLD;
    assign body_load  = !sts.is_close;

    // parse step decode
    always_comb
    begin
        dec_phase = phase_reg;
        dec_op1   = spm_pkg::OP_NONE;
        dec_src1  = spm_pkg::SRC_HOLD;
        dec_op2   = spm_pkg::OP_NONE;
        dec_src2  = spm_pkg::SRC_UNIT;
        dec_load  = 1'b0;
        unique case (phase_reg)
            spm_pkg::PH_FIRST:
            begin
                if (sts.is_caret)
                begin
                    dec_op1   = spm_pkg::OP_CARET;
                    dec_phase = spm_pkg::PH_AFTER_CARET;
                end
                else if (sts.is_close)
                begin
                    dec_op1   = spm_pkg::OP_SINGLE;
                    dec_src1  = spm_pkg::SRC_UNIT;
                    dec_phase = spm_pkg::PH_MAIN;
                end
                else
                begin
                    dec_phase = body_phase;
                    dec_load  = body_load;
                end
            end
            spm_pkg::PH_AFTER_CARET:
            begin
                if (sts.is_close)
                begin
                    dec_op1   = spm_pkg::OP_SINGLE;
                    dec_src1  = spm_pkg::SRC_UNIT;
                    dec_phase = spm_pkg::PH_MAIN;
                end
                else
                begin
                    dec_phase = body_phase;
                    dec_load  = body_load;
                end
            end
            spm_pkg::PH_MAIN:
            begin
                dec_phase = body_phase;
                dec_load  = body_load;
            end
            spm_pkg::PH_HOLD:
            begin
                if (sts.is_dash)
                begin
                    dec_phase = spm_pkg::PH_DASH;
                end
                else
                begin
                    dec_op1   = spm_pkg::OP_SINGLE;
                    dec_src1  = spm_pkg::SRC_HOLD;
                    dec_phase = body_phase;
                    dec_load  = body_load;
                end
            end
            spm_pkg::PH_DASH:
            begin
                if (!sts.is_close)
                begin
                    dec_op1   = spm_pkg::OP_RANGE;
                    dec_phase = spm_pkg::PH_MAIN;
                end
                else
                begin
                    dec_op1   = spm_pkg::OP_SINGLE;
                    dec_src1  = spm_pkg::SRC_HOLD;
                    dec_op2   = spm_pkg::OP_SINGLE;
                    dec_src2  = spm_pkg::SRC_DASH;
                    dec_phase = spm_pkg::PH_DONE;
                end
            end
            default:
            begin
            end
        endcase
        // end of text flushes the lookahead
        if (sts.item_last && phase_reg != spm_pkg::PH_DONE && dec_phase != spm_pkg::PH_DONE)
        begin
            if (dec_phase == spm_pkg::PH_HOLD)
            begin
                // held unit is the current one
                if (dec_op1 == spm_pkg::OP_NONE)
                begin
                    dec_op1  = spm_pkg::OP_SINGLE;
                    dec_src1 = spm_pkg::SRC_UNIT;
                end
                else
                begin
                    dec_op2  = spm_pkg::OP_SINGLE;
                    dec_src2 = spm_pkg::SRC_UNIT;
                end
            end
            else if (dec_phase == spm_pkg::PH_DASH)
            begin
                dec_op1  = spm_pkg::OP_SINGLE;
                dec_src1 = spm_pkg::SRC_HOLD;
                dec_op2  = spm_pkg::OP_SINGLE;
                dec_src2 = spm_pkg::SRC_DASH;
            end
            dec_phase = spm_pkg::PH_DONE;
        end
    end

    // sequencer next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            spm_pkg::ST_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = spm_pkg::ST_EXEC;
                end
            end
            spm_pkg::ST_EXEC:
            begin
                if (sts.item_mode == spm_pkg::MODE_SPEC && dec_op2 != spm_pkg::OP_NONE)
                begin
                    state_next = spm_pkg::ST_ADD2;
                end
                else
                begin
                    state_next = spm_pkg::ST_OUT;
                end
            end
            spm_pkg::ST_ADD2:
            begin
                state_next = spm_pkg::ST_OUT;
            end
            spm_pkg::ST_OUT:
            begin
                if (out_ready)
                begin
                    state_next = spm_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = spm_pkg::ST_IDLE;
            end
        endcase
    end

    // sequencer outputs and datapath commands
    always_comb
    begin
        in_ready      = 1'b0;
        out_valid     = 1'b0;
        cmd.capture   = 1'b0;
        cmd.clear     = 1'b0;
        cmd.query     = 1'b0;
        cmd.spec_exec = 1'b0;
        cmd.op        = spm_pkg::OP_NONE;
        cmd.src       = spm_pkg::SRC_HOLD;
        cmd.load_hold = 1'b0;
        unique case (state_reg)
            spm_pkg::ST_IDLE:
            begin
                in_ready    = 1'b1;
                cmd.capture = in_valid;
                cmd.clear   = in_valid && sts.start_set;
            end
            spm_pkg::ST_EXEC:
            begin
                if (sts.item_mode == spm_pkg::MODE_QUERY)
                begin
                    cmd.query = 1'b1;
                end
                else
                begin
                    cmd.spec_exec = 1'b1;
                    cmd.op        = dec_op1;
                    cmd.src       = dec_src1;
                    cmd.load_hold = dec_load;
                end
            end
            spm_pkg::ST_ADD2:
            begin
                cmd.op  = op2_reg;
                cmd.src = src2_reg;
            end
            spm_pkg::ST_OUT:
            begin
                out_valid = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    // parse phase and second add
    always_comb
    begin
        phase_next = phase_reg;
        op2_next   = op2_reg;
        src2_next  = src2_reg;
        if (cmd.clear)
        begin
            phase_next = spm_pkg::PH_FIRST;
        end
        else if (cmd.spec_exec)
        begin
            phase_next = dec_phase;
            op2_next   = dec_op2;
            src2_next  = dec_src2;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= spm_pkg::ST_IDLE;
            phase_reg <= spm_pkg::PH_FIRST;
            op2_reg   <= spm_pkg::OP_NONE;
            src2_reg  <= spm_pkg::SRC_HOLD;
        end
        else
        begin
            state_reg <= state_next;
            phase_reg <= phase_next;
            op2_reg   <= op2_next;
            src2_reg  <= src2_next;
        end
    end

    assign spec_done = (phase_reg == spm_pkg::PH_DONE);

    // checks
    `SPM_ASSERT_IMPL(a_one_side, in_ready, !out_valid)
    `SPM_ASSERT_NEXT(a_accept_exec, in_valid && in_ready, state_reg == spm_pkg::ST_EXEC)
    `SPM_ASSERT_NEXT(a_done_sticky,
        phase_reg == spm_pkg::PH_DONE && !cmd.clear, phase_reg == spm_pkg::PH_DONE)

endmodule

`default_nettype wire

[design/scanset_parse_and_match_top.sv]
// ---------------------------------------------------------------------------
// scanset_parse_and_match_top
// bracket character-class parser with single and range stores and a
// membership matcher
// ---------------------------------------------------------------------------
// channel  dir  tdata                tuser                      tlast
// s_*      in   [15:0] code_unit     [0] mode, [1] first_unit   end_of_text
// m_*      out  [15:0] consumed      [0] in_set, [1] add_ok     spec_done
//
// one request at a time: accept in ST_IDLE, execute in ST_EXEC, a
// second add in ST_ADD2 when a parse step stores two singles, then the
// result is held on m_* in ST_OUT until taken; the second add step comes
// from the single store write port
// reset (rst_n low) empties both stores, sets the set inclusive and zeroes
// the consumed count; no clearing pass is needed
// a stall on m_tready holds the result and blocks s_tready
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module scanset_parse_and_match_top (
    input  wire logic        clk,
    input  wire logic        rst_n,
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // [15:0] code_unit
    input  wire logic [1:0]  s_tuser,   // [0] mode, [1] first_unit
    input  wire logic        s_tlast,
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic [15:0]      m_tdata,   // [15:0] consumed
    output logic [1:0]       m_tuser,   // [0] in_set, [1] add_ok
    output logic             m_tlast
);

    spm_pkg::cmd_t    cmd;
    spm_pkg::status_t sts;
    logic             in_set;
    logic             add_ok;
    logic             spec_done;
    logic [15:0]      consumed;

    // sequencer and parse control
    spm_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (s_tvalid),
        .in_ready  (s_tready),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .sts       (sts),
        .cmd       (cmd),
        .spec_done (spec_done)
    );

    // stores, counters and matcher
    spm_datapath u_dp (
        .clk      (clk),
        .rst_n    (rst_n),
        .cmd      (cmd),
        .sts      (sts),
        .in_mode  (s_tuser[0]),
        .in_unit  (s_tdata),
        .in_first (s_tuser[1]),
        .in_last  (s_tlast),
        .in_set   (in_set),
        .add_ok   (add_ok),
        .consumed (consumed)
    );

    // result packing
    assign m_tdata = consumed;
    assign m_tuser = {add_ok, in_set};
    assign m_tlast = spec_done;

endmodule

`default_nettype wire

[bench/testbench.sv]
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// testbench
// self-checking bench for the bracket character-class parser and matcher:
// streams set texts and membership queries, predicts every result in the
// bench and compares the returned fields against the oldest prediction
// ---------------------------------------------------------------------------

module testbench;

    localparam int LIMIT_CYCLES = 400000;
    localparam int RANDOM_ITEMS = 1450;
    localparam int DRAIN_CYCLES = 8;

    // one request toward the block
    typedef struct packed {
        logic        mode;
        logic [15:0] unit;
        logic        first;
        logic        eot;
    } scan_req_t;

    // one result from the block
    typedef struct packed {
        logic        in_set;
        logic        add_ok;
        logic        done;
        logic [15:0] consumed;
    } match_result_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;
    logic [1:0]  s_tuser  = '0;
    logic        s_tlast  = 1'b0;
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [15:0] m_tdata;
    logic [1:0]  m_tuser;
    logic        m_tlast;

    scan_req_t     pending_reqs[$];
    match_result_t expected_results[$];
    logic [15:0]   recent_units[$];

    logic req_taken   = 1'b0;
    int   n_accepted  = 0;
    int   n_total     = 0;
    int   stim_count  = 0;
    int   n_results   = 0;
    int   fail_count  = 0;
    int   cycle_count = 0;

    // bench copy of the set and parse state
    logic            set_inclusive;
    logic [15:0]     single_vals[spm_pkg::ENTRY_SLOTS];
    int              single_cnt;
    logic [15:0]     range_lo[spm_pkg::ENTRY_SLOTS];
    logic [15:0]     range_hi[spm_pkg::ENTRY_SLOTS];
    int              range_cnt;
    spm_pkg::phase_t parse_ph;
    logic [15:0]     held_unit;
    logic [15:0]     held_dash;
    int              consumed_cnt;
    logic            add_result;

    scanset_parse_and_match_top dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .s_tlast  (s_tlast),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    // clock
    always
    begin
        clk = 1'b0;
        #1;
        clk = 1'b1;
        #1;
    end

    // ----------------------------------------------------------------------
    // set state prediction
    // ----------------------------------------------------------------------

    function automatic void clear_set();
        set_inclusive = 1'b1;
        single_cnt    = 0;
        range_cnt     = 0;
        parse_ph      = spm_pkg::PH_FIRST;
        held_unit     = '0;
        held_dash     = '0;
        consumed_cnt  = 0;
        add_result    = 1'b0;
        for (int i = 0; i < spm_pkg::ENTRY_SLOTS; i++)
        begin
            single_vals[i] = '0;
            range_lo[i]    = '0;
            range_hi[i]    = '0;
        end
    endfunction

    // consumed count saturates at 16 bits
    function automatic void bump(int n);
        consumed_cnt = (consumed_cnt + n > 65535) ? 65535 : consumed_cnt + n;
    endfunction

    // a list is full once it holds all but one slot
    function automatic void add_single(logic [15:0] u);
        if (single_cnt >= spm_pkg::ENTRY_SLOTS - 1)
        begin
            add_result = 1'b0;
        end
        else
        begin
            single_vals[single_cnt] = u;
            single_cnt++;
            add_result = 1'b1;
        end
    endfunction

    function automatic void add_range(logic [15:0] a, logic [15:0] b);
        if (range_cnt >= spm_pkg::ENTRY_SLOTS - 1)
        begin
            add_result = 1'b0;
        end
        else
        begin
            range_lo[range_cnt] = (b < a) ? b : a;
            range_hi[range_cnt] = (b < a) ? a : b;
            range_cnt++;
            add_result = 1'b1;
        end
    endfunction

    // ordinary text unit: close bracket ends, anything else waits for a dash
    function automatic void take_body(logic [15:0] u);
        if (u == spm_pkg::CH_CLOSE)
        begin
            parse_ph = spm_pkg::PH_DONE;
        end
        else
        begin
            held_unit = u;
            parse_ph  = spm_pkg::PH_HOLD;
        end
    endfunction

    function automatic logic is_member(logic [15:0] u);
        logic hit;
        hit = 1'b0;
        for (int i = 0; i < single_cnt; i++)
            if (single_vals[i] == u)
                hit = 1'b1;
        for (int i = 0; i < range_cnt; i++)
            if (u >= range_lo[i] && u <= range_hi[i])
                hit = 1'b1;
        return set_inclusive ? hit : !hit;
    endfunction

    function automatic void parse_spec(logic [15:0] u, logic first, logic eot);
        if (first)
            clear_set();
        case (parse_ph)
            spm_pkg::PH_FIRST, spm_pkg::PH_AFTER_CARET:
            begin
                if (parse_ph == spm_pkg::PH_FIRST && u == spm_pkg::CH_CARET)
                begin
                    set_inclusive = 1'b0;
                    bump(1);
                    parse_ph = spm_pkg::PH_AFTER_CARET;
                end
                else if (u == spm_pkg::CH_CLOSE)
                begin
                    // leading close bracket is a literal member
                    add_single(u);
                    bump(1);
                    parse_ph = spm_pkg::PH_MAIN;
                end
                else
                begin
                    take_body(u);
                end
            end
            spm_pkg::PH_MAIN:
            begin
                take_body(u);
            end
            spm_pkg::PH_HOLD:
            begin
                if (u == spm_pkg::CH_DASH)
                begin
                    held_dash = u;
                    parse_ph  = spm_pkg::PH_DASH;
                end
                else
                begin
                    add_single(held_unit);
                    bump(1);
                    take_body(u);
                end
            end
            spm_pkg::PH_DASH:
            begin
                if (u != spm_pkg::CH_CLOSE)
                begin
                    add_range(held_unit, u);
                    bump(3);
                    parse_ph = spm_pkg::PH_MAIN;
                end
                else
                begin
                    // dash before the close bracket is a plain member
                    add_single(held_unit);
                    bump(1);
                    add_single(held_dash);
                    bump(1);
                    parse_ph = spm_pkg::PH_DONE;
                end
            end
            default:
            begin
                return;
            end
        endcase
        // text ran out: flush whatever is held for lookahead
        if (eot && parse_ph != spm_pkg::PH_DONE)
        begin
            if (parse_ph == spm_pkg::PH_HOLD)
            begin
                add_single(held_unit);
                bump(1);
            end
            else if (parse_ph == spm_pkg::PH_DASH)
            begin
                add_single(held_unit);
                bump(1);
                add_single(held_dash);
                bump(1);
            end
            parse_ph = spm_pkg::PH_DONE;
        end
    endfunction

    function automatic void predict_result(scan_req_t r);
        match_result_t e;
        e.in_set = 1'b0;
        if (r.mode == spm_pkg::MODE_QUERY)
            e.in_set = is_member(r.unit);
        else
            parse_spec(r.unit, r.first, r.eot);
        e.add_ok   = add_result;
        e.done     = (parse_ph == spm_pkg::PH_DONE);
        e.consumed = consumed_cnt[15:0];
        expected_results.push_back(e);
    endfunction

    // ----------------------------------------------------------------------
    // stimulus generation
    // ----------------------------------------------------------------------

    task automatic push_req(logic mode, logic [15:0] unit, logic first, logic eot,
                            bit counted);
        scan_req_t r;
        r.mode  = mode;
        r.unit  = unit;
        r.first = first;
        r.eot   = eot;
        pending_reqs.push_back(r);
        if (counted)
            stim_count++;
    endtask

    function automatic logic [15:0] body_char();
        int pick;
        pick = $urandom_range(0, 99);
        if (pick < 4)
            return spm_pkg::CH_CLOSE;
        else if (pick < 12)
            return spm_pkg::CH_DASH;
        else if (pick < 17)
            return spm_pkg::CH_CARET;
        else if (pick < 65)
            return 16'($urandom_range(16'h0021, 16'h007E));
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    function automatic logic [15:0] query_char();
        int          pick;
        logic [15:0] v;
        pick = $urandom_range(0, 99);
        if (pick < 35 && recent_units.size() != 0)
        begin
            // near a unit of the current text, to hit range edges
            v = recent_units[$urandom_range(0, recent_units.size() - 1)];
            case ($urandom_range(0, 2))
                0: v = v - 16'd1;
                2: v = v + 16'd1;
                default: ;
            endcase
            return v;
        end
        else if (pick < 50)
        begin
            case ($urandom_range(0, 4))
                0: return 16'h0000;
                1: return 16'hFFFF;
                2: return spm_pkg::CH_CARET;
                3: return spm_pkg::CH_CLOSE;
                default: return spm_pkg::CH_DASH;
            endcase
        end
        else if (pick < 75)
            return 16'($urandom_range(16'h0021, 16'h007E));
        else
            return 16'($urandom_range(0, 65535));
    endfunction

    task automatic push_query();
        push_req(spm_pkg::MODE_QUERY, query_char(),
                 1'($urandom_range(0, 1)) & 1'($urandom_range(0, 1)),
                 1'($urandom_range(0, 1)) & 1'($urandom_range(0, 1)), 1);
    endtask

    // one bracket text with random content, then a burst of queries
    task automatic gen_text();
        logic [15:0] body[$];
        int          len;
        int          ending;
        bit          eot_tail;
        logic [15:0] c;
        body     = {};
        eot_tail = 0;
        if ($urandom_range(0, 99) < 30)
            body.push_back(spm_pkg::CH_CARET);
        if ($urandom_range(0, 99) < 15)
            body.push_back(spm_pkg::CH_CLOSE);
        // mostly short texts, a few long enough to fill the lists
        len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(0, 8);
        for (int i = 0; i < len; i++)
        begin
            c = body_char();
            if (c == spm_pkg::CH_CLOSE && $urandom_range(0, 1) == 0)
                c = 16'($urandom_range(0, 65535));
            body.push_back(c);
            if ($urandom_range(0, 99) < 40)
            begin
                body.push_back(spm_pkg::CH_DASH);
                body.push_back(body_char());
            end
        end
        ending = $urandom_range(0, 9);
        case (ending)
            0, 1, 2, 3:
                body.push_back(spm_pkg::CH_CLOSE);
            4, 5:
            begin
                if (body.size() == 0)
                    body.push_back(body_char());
                eot_tail = 1;
            end
            6:
            begin
                body.push_back(body_char());
                body.push_back(spm_pkg::CH_DASH);
                eot_tail = 1;
            end
            7, 8:
            begin
                body.push_back(body_char());
                body.push_back(spm_pkg::CH_DASH);
                body.push_back(spm_pkg::CH_CLOSE);
            end
            default:
            begin
                // broken text: no terminator, the next first unit cuts it off
                if (body.size() == 0)
                    body.push_back(body_char());
            end
        endcase
        recent_units = {};
        for (int i = 0; i < body.size(); i++)
        begin
            recent_units.push_back(body[i]);
            push_req(spm_pkg::MODE_SPEC, body[i], i == 0,
                     eot_tail && i == body.size() - 1, 1);
            if ($urandom_range(0, 99) < 8)
                push_query();
        end
        // stray spec units after the text ends
        if ($urandom_range(0, 99) < 10)
            push_req(spm_pkg::MODE_SPEC, body_char(), 1'b0, 1'($urandom_range(0, 1)), 0);
        repeat ($urandom_range(1, 6))
            push_query();
    endtask

    task automatic load_directed();
        // empty set after reset
        push_req(spm_pkg::MODE_QUERY, 16'h0061, 1'b0, 1'b0, 1);
        // text starting without the first flag, held unit not yet a member
        push_req(spm_pkg::MODE_SPEC,  16'h0061, 1'b0, 1'b0, 1);
        push_req(spm_pkg::MODE_SPEC,  spm_pkg::CH_DASH,  1'b0, 1'b0, 1);
        push_req(spm_pkg::MODE_QUERY, 16'h0061, 1'b0, 1'b0, 1);
        push_req(spm_pkg::MODE_SPEC,  16'h007A, 1'b0, 1'b0, 1);
        push_req(spm_pkg::MODE_SPEC,  spm_pkg::CH_CLOSE, 1'b0, 1'b0, 1);
        // spec after done is dropped; query ignores first and end flags
        push_req(spm_pkg::MODE_SPEC,  16'h0062, 1'b0, 1'b0, 1);
        push_req(spm_pkg::MODE_QUERY, 16'h0061, 1'b1, 1'b1, 1);
        // exclusive set with literal close and a dash before the close
        push_req(spm_pkg::MODE_SPEC,  spm_pkg::CH_CARET, 1'b1, 1'b0, 1);
        push_req(spm_pkg::MODE_SPEC,  spm_pkg::CH_CLOSE, 1'b0, 1'b0, 1);
        push_req(spm_pkg::MODE_SPEC,  16'hFFFF, 1'b0, 1'b0, 1);
        push_req(spm_pkg::MODE_SPEC,  spm_pkg::CH_DASH,  1'b0, 1'b0, 1);
        push_req(spm_pkg::MODE_SPEC,  spm_pkg::CH_CLOSE, 1'b0, 1'b0, 1);
        push_req(spm_pkg::MODE_QUERY, 16'h0000, 1'b0, 1'b0, 1);
        push_req(spm_pkg::MODE_QUERY, 16'hFFFF, 1'b0, 1'b0, 1);
        // reversed range bounds ended by end of text
        push_req(spm_pkg::MODE_SPEC,  16'h007A, 1'b1, 1'b0, 1);
        push_req(spm_pkg::MODE_SPEC,  spm_pkg::CH_DASH,  1'b0, 1'b0, 1);
        push_req(spm_pkg::MODE_SPEC,  16'h0000, 1'b0, 1'b1, 1);
        push_req(spm_pkg::MODE_QUERY, 16'h0030, 1'b0, 1'b0, 1);
        // lone close bracket, unit plus dash at end, single unit at end
        push_req(spm_pkg::MODE_SPEC,  spm_pkg::CH_CLOSE, 1'b1, 1'b1, 1);
        push_req(spm_pkg::MODE_SPEC,  16'h0071, 1'b1, 1'b0, 1);
        push_req(spm_pkg::MODE_SPEC,  spm_pkg::CH_DASH,  1'b0, 1'b1, 1);
        push_req(spm_pkg::MODE_SPEC,  16'h8000, 1'b1, 1'b1, 1);
        push_req(spm_pkg::MODE_QUERY, 16'h8000, 1'b0, 1'b0, 1);
    endtask

    // ----------------------------------------------------------------------
    // driver
    // ----------------------------------------------------------------------

    // idle percentages per third of the run: sender, then receiver
    function automatic int gap_pct(bit sender);
        if (n_accepted < n_total / 3)
            return sender ? 34 : 59;
        else if (n_accepted < 2 * n_total / 3)
            return sender ? 59 : 34;
        else
            return 0;
    endfunction

    always @(posedge clk)
    begin
        req_taken <= s_tvalid && s_tready;
        if (s_tvalid && s_tready)
        begin
            predict_result(pending_reqs.pop_front());
            n_accepted++;
        end
    end

    always @(negedge clk)
    begin
        if (!rst_n)
        begin
            s_tvalid <= 1'b0;
        end
        else if (!s_tvalid || req_taken)
        begin
            if (pending_reqs.size() != 0 && $urandom_range(0, 99) >= gap_pct(1))
            begin
                s_tvalid <= 1'b1;
                s_tdata  <= pending_reqs[0].unit;
                s_tuser  <= {pending_reqs[0].first, pending_reqs[0].mode};
                s_tlast  <= pending_reqs[0].eot;
            end
            else
            begin
                s_tvalid <= 1'b0;
            end
        end
        m_tready <= ($urandom_range(0, 99) >= gap_pct(0));
    end

    // ----------------------------------------------------------------------
    // monitor
    // ----------------------------------------------------------------------

    task automatic note_failure(string msg);
        fail_count++;
        if (fail_count <= 10)
            $display("%s", msg);
    endtask

    always @(posedge clk)
    begin : monitor
        match_result_t e;
        if (rst_n && m_tvalid && m_tready)
        begin
            n_results++;
            if (expected_results.size() == 0)
            begin
                note_failure($sformatf("result %0d arrived with nothing pending", n_results));
            end
            else
            begin
                e = expected_results.pop_front();
                if (m_tuser[0] !== e.in_set || m_tuser[1] !== e.add_ok ||
                    m_tlast !== e.done || m_tdata !== e.consumed)
                    note_failure($sformatf({"result %0d mismatch: in_set %0b/%0b ",
                        "add_ok %0b/%0b spec_done %0b/%0b consumed %0d/%0d (exp/got)"},
                        n_results, e.in_set, m_tuser[0], e.add_ok, m_tuser[1],
                        e.done, m_tlast, e.consumed, m_tdata));
            end
        end
    end

    // run limit
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > LIMIT_CYCLES)
        begin
            $display("simulation failed");
            $finish;
        end
    end

    // ----------------------------------------------------------------------
    // sequence
    // ----------------------------------------------------------------------

    initial
    begin
        clear_set();
        load_directed();
        stim_count = 0;
        while (stim_count < RANDOM_ITEMS)
            gen_text();
        n_total = pending_reqs.size();

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        while (pending_reqs.size() != 0 || expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);

        if (fail_count == 0 && expected_results.size() == 0)
            $display("simulation ok");
        else
            $display("simulation failed");
        $finish;
    end

endmodule

[files.f]
+incdir+design
design/spm_pkg.sv
design/spm_datapath.sv
design/spm_ctrl.sv
design/scanset_parse_and_match_top.sv
bench/testbench.sv
